// ----- rtl/core/htirc_pkg.sv -----
package htirc_pkg;

  // Default number of valid samples in one average report.
  localparam int DEFAULT_SAMPLES_PER_AVERAGE = 12;

  // Field widths.
  localparam int TEMP_W = 12;
  localparam int BAND_W = 12;
  localparam int CMD_W  = 16;
  localparam int SUM_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_ABOVE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_BELOW = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_ON  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_MODE  = 3'd4;

  // Register reset values.
  localparam logic signed [TEMP_W-1:0] SETPOINT_RESET   = 12'sd416;
  localparam logic [BAND_W-1:0]        BAND_ABOVE_RESET = 12'd16;
  localparam logic [BAND_W-1:0]        BAND_BELOW_RESET = 12'd16;

  // Infrared command words.
  localparam logic [CMD_W-1:0] CMD_POWER = 16'h0075;
  localparam logic [CMD_W-1:0] CMD_SET22 = 16'h0875;
  localparam logic [CMD_W-1:0] CMD_OFF   = 16'hC005;

  // Result kinds.
  localparam logic KIND_IR      = 1'b0;
  localparam logic KIND_AVERAGE = 1'b1;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     sensor_ok;
  } in_item_t;

  typedef struct packed {
    logic                     kind;
    logic [CMD_W-1:0]         ir_command;
    logic signed [TEMP_W-1:0] average_temp;
    logic                     cooler_on;
    logic                     last;
  } out_item_t;

endpackage

// ----- rtl/core/hysteresis_thermostat_ir_control_core.sv -----
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_data    (htirc_pkg::in_item_t)
// out      output     out_valid / out_stall  out_data   (htirc_pkg::out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample is registered on transfer and evaluated when the result buffer is empty
// or its last result leaves, and its zero to three results are loaded into the
// three-entry result buffer at once. Results leave one per cycle unless out_stall
// holds them; a new sample can be taken and held while earlier results drain.
// A sample with sensor_ok low is taken and dropped. Synchronous reset clears
// the buffer, the control state and the registers to their reset values.
// The input stalls only while the held sample cannot move into the buffer.
module hysteresis_thermostat_ir_control_core #(
  parameter int SAMPLES_PER_AVERAGE = htirc_pkg::DEFAULT_SAMPLES_PER_AVERAGE
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  htirc_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output htirc_pkg::out_item_t                 out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [htirc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [htirc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TempW = htirc_pkg::TEMP_W;
  localparam int SumW  = htirc_pkg::SUM_W;
  localparam int CountW = $clog2(SAMPLES_PER_AVERAGE);
  localparam logic [CountW-1:0] CountLast = CountW'(SAMPLES_PER_AVERAGE - 1);
  // Reciprocal for an exact truncating divide of a 16-bit magnitude.
  localparam int RecipShift = SumW + $clog2(SAMPLES_PER_AVERAGE);
  localparam int RecipW = SumW + 2;
  localparam longint RecipFull =
    ((64'sd1 <<< RecipShift) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);

  // Configuration registers.
  logic signed [TempW-1:0]             setpoint;
  logic [htirc_pkg::BAND_W-1:0]        band_above;
  logic [htirc_pkg::BAND_W-1:0]        band_below;
  logic                                manual_on;
  logic                                auto_mode;

  // Control and averaging state.
  logic                                cooler_state;
  logic signed [SumW-1:0]              sample_sum;
  logic [CountW-1:0]                   sample_count;

  // Held sample stage.
  logic                                a_valid;
  logic signed [TempW-1:0]             a_temp;
  logic signed [SumW-1:0]              a_sum;
  logic                                a_report;

  // Result buffer.
  htirc_pkg::out_item_t                slot [3];
  logic [1:0]                          b_count;

  logic                                in_fire;
  logic                                out_fire;
  logic                                load_b;
  logic signed [SumW-1:0]              sum_next;

  logic signed [TempW+1:0]             t_ext;
  logic signed [TempW+1:0]             on_level;
  logic signed [TempW+1:0]             off_level;
  logic                                want;
  logic                                turn_on;
  logic                                turn_off;
  logic                                mag_neg;
  logic [SumW-1:0]                     mag;
  logic [SumW+RecipW-1:0]              product;
  logic [TempW-1:0]                    quot;
  logic signed [TempW-1:0]             avg;
  htirc_pkg::out_item_t                res [3];
  logic [1:0]                          res_count;

  assign cfg_ready = 1'b1;
  assign out_valid = (b_count != 2'd0);
  assign out_data  = slot[0];
  assign out_fire  = out_valid && !out_stall;
  assign load_b    = a_valid && ((b_count == 2'd0) || ((b_count == 2'd1) && out_fire));
  assign in_stall  = a_valid && !load_b;
  assign in_fire   = in_valid && !in_stall;
  assign sum_next  = sample_sum + SumW'(in_data.temperature);

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= htirc_pkg::SETPOINT_RESET;
      band_above <= htirc_pkg::BAND_ABOVE_RESET;
      band_below <= htirc_pkg::BAND_BELOW_RESET;
      manual_on  <= 1'b0;
      auto_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        htirc_pkg::REG_SETPOINT:   setpoint   <= $signed(cfg_data[TempW-1:0]);
        htirc_pkg::REG_BAND_ABOVE: band_above <= cfg_data[htirc_pkg::BAND_W-1:0];
        htirc_pkg::REG_BAND_BELOW: band_below <= cfg_data[htirc_pkg::BAND_W-1:0];
        htirc_pkg::REG_MANUAL_ON:  manual_on  <= cfg_data[0];
        htirc_pkg::REG_AUTO_MODE:  auto_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Running sum and count advance on each valid sample transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (in_fire && in_data.sensor_ok) begin
      if (sample_count == CountLast) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_next;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  // Held sample: valid flag under reset, payload without.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire && in_data.sensor_ok) begin
      a_valid <= 1'b1;
    end else if (load_b) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.sensor_ok) begin
      a_temp   <= in_data.temperature;
      a_sum    <= sum_next;
      a_report <= (sample_count == CountLast);
    end
  end

  // Hysteresis decision in auto mode, compared at full precision; manual mode follows manual_on.
  always_comb begin
    t_ext     = $signed({{2{a_temp[TempW-1]}}, a_temp});
    on_level  = $signed({{2{setpoint[TempW-1]}}, setpoint}) + $signed({2'b00, band_above});
    off_level = $signed({{2{setpoint[TempW-1]}}, setpoint}) - $signed({2'b00, band_below});
    want = cooler_state;
    if (auto_mode) begin
      if (t_ext >= on_level) begin
        want = 1'b1;
      end else if (t_ext <= off_level) begin
        want = 1'b0;
      end
    end else begin
      want = manual_on;
    end
    turn_on  = want && !cooler_state;
    turn_off = !want && cooler_state;
  end

  // Average: magnitude times reciprocal, then the sign restored.
  always_comb begin
    mag_neg = a_sum[SumW-1];
    mag     = mag_neg ? SumW'(-a_sum) : SumW'(a_sum);
    product = (SumW+RecipW)'(mag) * (SumW+RecipW)'(Recip);
    quot    = product[RecipShift +: TempW];
    avg     = mag_neg ? $signed(-quot) : $signed(quot);
  end

  // Results of the held sample, in emission order.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i].kind         = htirc_pkg::KIND_IR;
      res[i].ir_command   = '0;
      res[i].average_temp = '0;
      res[i].cooler_on    = want;
      res[i].last         = 1'b0;
    end
    if (turn_on) begin
      res[0].ir_command   = htirc_pkg::CMD_POWER;
      res[1].ir_command   = htirc_pkg::CMD_SET22;
      res[2].kind         = htirc_pkg::KIND_AVERAGE;
      res[2].average_temp = avg;
      res_count = a_report ? 2'd3 : 2'd2;
    end else if (turn_off) begin
      res[0].ir_command   = htirc_pkg::CMD_OFF;
      res[1].kind         = htirc_pkg::KIND_AVERAGE;
      res[1].average_temp = avg;
      res_count = a_report ? 2'd2 : 2'd1;
    end else begin
      res[0].kind         = htirc_pkg::KIND_AVERAGE;
      res[0].average_temp = avg;
      res_count = a_report ? 2'd1 : 2'd0;
    end
    for (int i = 0; i < 3; i++) begin
      res[i].last = (res_count == 2'(i + 1));
    end
  end

  // Cooler state follows the decision when the sample is evaluated.
  always_ff @(posedge clk) begin
    if (rst) begin
      cooler_state <= 1'b0;
    end else if (load_b) begin
      cooler_state <= want;
    end
  end

  // Result buffer: loaded whole, drained from the front.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_count <= 2'd0;
    end else if (load_b) begin
      b_count <= res_count;
    end else if (out_fire) begin
      b_count <= b_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      slot[0] <= res[0];
      slot[1] <= res[1];
      slot[2] <= res[2];
    end else if (out_fire) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule
